FILE: rtl/core/decal_pool_fifo_evict_fade_assert.svh
// ---------------------------------------------------------------------------
// decal pool assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef DECAL_POOL_FIFO_EVICT_FADE_ASSERT_SVH
`define DECAL_POOL_FIFO_EVICT_FADE_ASSERT_SVH

// same-cycle implication
`define DPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decal pool check failed");

// next-cycle implication
`define DPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decal pool check failed");

`endif

FILE: rtl/core/dpf_pkg.sv
// ---------------------------------------------------------------------------
// dpf_pkg
// shared types and constants of the decal pool
// ---------------------------------------------------------------------------
package dpf_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 64;
  localparam int unsigned IDX_OUT_W        = 6;
  localparam int unsigned LVL_W            = 7;
  localparam logic [LVL_W-1:0] LEVEL_MAX   = 7'd127;
  localparam logic [31:0] HOLD_RESET       = 32'd90000;
  localparam logic [31:0] FADE_RESET       = 32'd120000;

  // register indexes
  localparam logic CFG_HOLD = 1'b0;
  localparam logic CFG_FADE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_SPRAY = 2'd0;
  localparam logic [1:0] KIND_VIS   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // input mode
  localparam logic MODE_SPRAY = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic signed [19:0] cz;
    logic [11:0]        rad;
    logic [LVL_W-1:0]   lvl;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } entry_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IDX_OUT_W-1:0] idx;
    logic [LVL_W-1:0]     lvl;
    logic                 ev;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic                 last;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/core/dpf_mul.sv
// ---------------------------------------------------------------------------
// dpf_mul
// shared 32x32 unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module dpf_mul import dpf_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/core/dpf_div.sv
// ---------------------------------------------------------------------------
// dpf_div
// restoring divider, one quotient bit per cycle, 8-bit quotient
// dividend must be below 256 times the divisor
// ---------------------------------------------------------------------------
module dpf_div import dpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output logic     busy,
  output logic [7:0] quot
);

  logic [3:0]  steps;
  logic [31:0] rem;
  logic [7:0]  low;
  logic [31:0] den;
  logic [32:0] trial;

  assign trial = {rem, low[7]};
  assign busy  = (steps != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 4'd0;
    end else if (req.start) begin
      steps <= 4'd8;
    end else if (busy) begin
      steps <= steps - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[39:8];
      low <= req.dividend[7:0];
      den <= req.divisor;
    end else if (busy) begin
      low <= {low[6:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem  <= 32'(trial - {1'b0, den});
        quot <= {quot[6:0], 1'b1};
      end else begin
        rem  <= trial[31:0];
        quot <= {quot[6:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/decal_pool_fifo_evict_fade.sv
// ---------------------------------------------------------------------------
// decal_pool_fifo_evict_fade
// decal pool with free stack, in-use list in allocation order, fifo
// eviction and timed fade, run by a small sequencer around one shared
// multiplier and one bit-serial divider
// ---------------------------------------------------------------------------
//  channel   dir  handshake          content
//  s_*       in   s_tvalid/s_tready  spray or tick word, tuser = mode
//  m_*       out  m_tvalid/m_tready  result word, tuser = kind, tlast = last
//  cfg_*     in   cfg_we             hold_time (0), fade_end (1)
//
//  one word at a time; s_tready is high only while the sequencer is idle
//  spray: four multiplier passes per list entry, then the oldest entry is
//  evicted when none is free, plus output stalls
//  tick: expired entries are freed and unfaded ones passed on; a fading entry
//  takes four channels, each a multiplier pass then a divider run; plus one
//  result word per visible entry and output stalls
//  no clearing pass after reset; free stack reads its index until written
// ---------------------------------------------------------------------------
`include "decal_pool_fifo_evict_fade_assert.svh"

module decal_pool_fifo_evict_fade import dpf_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // now[31:0] cx[51:32] cy[71:52] cz[91:72] rad[103:92]
  // red[111:104] green[119:112] blue[127:120] alpha[135:128]
  input  logic [135:0] s_tdata,
  input  logic         s_tuser,   // mode
  input  logic         s_tvalid,
  output logic         s_tready,
  // idx[5:0] lvl[12:6] evicted[13] red[21:14] green[29:22]
  // blue[37:30] alpha[45:38] zero[47:46]
  output logic [47:0]  m_tdata,
  output logic [1:0]   m_tuser,   // kind
  output logic         m_tlast,   // last result of the item
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned IW = $clog2(POOL_ENTRIES);
  localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  // sequencer states
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_W_RD  = 5'd1;
  localparam logic [4:0] ST_W_MUL = 5'd2;
  localparam logic [4:0] ST_A0    = 5'd3;
  localparam logic [4:0] ST_R_RD  = 5'd4;
  localparam logic [4:0] ST_R_UPD = 5'd5;
  localparam logic [4:0] ST_A1    = 5'd6;
  localparam logic [4:0] ST_A2    = 5'd7;
  localparam logic [4:0] ST_A3    = 5'd8;
  localparam logic [4:0] ST_T_RD  = 5'd9;
  localparam logic [4:0] ST_T_AGE = 5'd10;
  localparam logic [4:0] ST_T_MUL = 5'd11;
  localparam logic [4:0] ST_T_MW  = 5'd12;
  localparam logic [4:0] ST_T_DIV = 5'd13;
  localparam logic [4:0] ST_T_PSH = 5'd14;
  localparam logic [4:0] ST_T_NXT = 5'd15;
  localparam logic [4:0] ST_T_END = 5'd16;
  localparam logic [4:0] ST_OUTW  = 5'd17;

  logic [4:0] state;

  // configuration
  logic [31:0] hold_time;
  logic [31:0] fade_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_RESET;
      fade_end  <= FADE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HOLD: hold_time <= cfg_data;
        CFG_FADE: fade_end  <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input word
  logic               mode;
  logic [31:0]        now_time;
  logic signed [19:0] in_cx, in_cy, in_cz;
  logic [11:0]        in_rad;
  logic [7:0]         in_red, in_green, in_blue, in_alpha;

  // list and free stack control
  logic [LW-1:0] head, tail, cur, nx;
  logic [CW-1:0] free_cnt;
  logic          evicted;
  logic [LVL_W-1:0] lvl;

  // per-entry stores, read at cur every cycle
  entry_t        ent_mem [POOL_ENTRIES];
  logic [LW-1:0] next_mem [POOL_ENTRIES];
  logic [LW-1:0] prev_mem [POOL_ENTRIES];
  entry_t        ent_q;
  logic [LW-1:0] next_q, prev_q;
  logic [IW-1:0] cur_idx;

  assign cur_idx = cur[IW-1:0];

  // free stack memory, an entry never written reads as its own index
  logic [IW-1:0]     fs_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] fs_valid;
  logic [IW-1:0]     fs_ra;
  logic [IW-1:0]     fs_q;
  logic              fs_we;

  assign fs_ra = IW'(free_cnt - CW'(1));

  // write ports
  logic          ent_we;
  logic          nxt_we, prv_we;
  logic [IW-1:0] nxt_wa, prv_wa;
  logic [LW-1:0] nxt_wd, prv_wd;
  entry_t        ent_wd;

  always_ff @(posedge clk) begin
    ent_q  <= ent_mem[cur_idx];
    next_q <= next_mem[cur_idx];
    prev_q <= prev_mem[cur_idx];
    if (ent_we) ent_mem[cur_idx] <= ent_wd;
    if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prev_mem[prv_wa] <= prv_wd;
  end

  always_ff @(posedge clk) begin
    fs_q <= fs_valid[fs_ra] ? fs_mem[fs_ra] : fs_ra;
    if (fs_we) fs_mem[IW'(free_cnt)] <= cur_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_valid <= '0;
    end else if (fs_we) begin
      fs_valid[IW'(free_cnt)] <= 1'b1;
    end
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [2:0]  k;
  logic [1:0]  ch;
  logic [31:0] num, den;

  dpf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  // spray distance operands
  logic signed [19:0] comp_e, comp_i;
  logic signed [20:0] diff;
  logic [20:0]        mag;
  logic [12:0]        rsum;
  logic [43:0]        acc;
  logic [26:0]        lim;
  logic               hit;
  logic [7:0]         byte_sel;

  always_comb begin
    case (k)
      3'd0:    begin comp_e = ent_q.cx; comp_i = in_cx; end
      3'd1:    begin comp_e = ent_q.cy; comp_i = in_cy; end
      default: begin comp_e = ent_q.cz; comp_i = in_cz; end
    endcase
    diff = {comp_e[19], comp_e} - {comp_i[19], comp_i};
    mag  = diff[20] ? 21'(-diff) : 21'(diff);
    rsum = {1'b0, in_rad} + {1'b0, ent_q.rad};
    case (ch)
      2'd0:    byte_sel = ent_q.red;
      2'd1:    byte_sel = ent_q.green;
      2'd2:    byte_sel = ent_q.blue;
      default: byte_sel = ent_q.alpha;
    endcase
    if (mode == MODE_TICK) begin
      mul_a = {24'd0, byte_sel};
      mul_b = num;
    end else if (k == 3'd3) begin
      mul_a = {19'd0, rsum};
      mul_b = {19'd0, rsum};
    end else begin
      mul_a = {11'd0, mag};
      mul_b = {11'd0, mag};
    end
    lim = {prod[25:0], 1'b0};
    hit = (ent_q.lvl >= lvl) && (acc < 44'(lim));
  end

  // divider for fading
  div_req_t    div_req;
  logic        div_busy;
  logic [7:0]  div_q;

  assign div_req.start    = (state == ST_T_MW);
  assign div_req.dividend = prod[39:0];
  assign div_req.divisor  = den;

  dpf_div u_div (.clk(clk), .rst(rst), .req(div_req), .busy(div_busy), .quot(div_q));

  // tick age
  logic [31:0] age;
  assign age = now_time - ent_q.stamp;

  // faded channels, pending visible word, output word
  logic [7:0] chan [4];
  out_word_t  pend, fresh, outw;
  logic       pend_v;
  logic       out_v;

  always_comb begin
    fresh.kind  = KIND_VIS;
    fresh.idx   = IDX_OUT_W'(cur_idx);
    fresh.lvl   = ent_q.lvl;
    fresh.ev    = 1'b0;
    fresh.red   = chan[0];
    fresh.green = chan[1];
    fresh.blue  = chan[2];
    fresh.alpha = chan[3];
    fresh.last  = 1'b0;
  end

  // memory write decode
  always_comb begin
    ent_we = 1'b0;
    nxt_we = 1'b0;
    prv_we = 1'b0;
    fs_we  = 1'b0;
    nxt_wa = cur_idx;
    prv_wa = cur_idx;
    nxt_wd = NIL;
    prv_wd = tail;
    ent_wd.stamp = now_time;
    ent_wd.cx    = in_cx;
    ent_wd.cy    = in_cy;
    ent_wd.cz    = in_cz;
    ent_wd.rad   = in_rad;
    ent_wd.lvl   = lvl;
    ent_wd.red   = in_red;
    ent_wd.green = in_green;
    ent_wd.blue  = in_blue;
    ent_wd.alpha = in_alpha;
    unique case (state)
      ST_R_UPD: begin
        // unlink cur and push it on the free stack
        fs_we  = 1'b1;
        nxt_we = (prev_q != NIL);
        nxt_wa = prev_q[IW-1:0];
        nxt_wd = next_q;
        prv_we = (next_q != NIL);
        prv_wa = next_q[IW-1:0];
        prv_wd = prev_q;
      end
      ST_A2: begin
        // popped entry: no successor, old tail as predecessor
        nxt_we = 1'b1;
        nxt_wa = fs_q;
        prv_we = 1'b1;
        prv_wa = fs_q;
      end
      ST_A3: begin
        // payload of the new entry, then hook it behind the old tail
        ent_we = 1'b1;
        nxt_we = (tail != NIL);
        nxt_wa = tail[IW-1:0];
        nxt_wd = cur;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= NIL;
      tail     <= NIL;
      cur      <= NIL;
      free_cnt <= CW'(POOL_ENTRIES);
      pend_v   <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode     <= s_tuser;
            now_time <= s_tdata[31:0];
            in_cx    <= s_tdata[51:32];
            in_cy    <= s_tdata[71:52];
            in_cz    <= s_tdata[91:72];
            in_rad   <= s_tdata[103:92];
            in_red   <= s_tdata[111:104];
            in_green <= s_tdata[119:112];
            in_blue  <= s_tdata[127:120];
            in_alpha <= s_tdata[135:128];
            lvl      <= LVL_W'(1);
            evicted  <= 1'b0;
            pend_v   <= 1'b0;
            cur      <= head;
            state    <= (s_tuser == MODE_TICK) ? ST_T_RD : ST_W_RD;
          end
        end
        // spray: level walk over the list, oldest first
        ST_W_RD: begin
          k     <= 3'd0;
          state <= (cur == NIL) ? ST_A0 : ST_W_MUL;
        end
        ST_W_MUL: begin
          k <= k + 3'd1;
          if (k == 3'd1) acc <= prod[43:0];
          else if (k == 3'd2 || k == 3'd3) acc <= acc + prod[43:0];
          if (k == 3'd4) begin
            if (hit) lvl <= (ent_q.lvl < LEVEL_MAX) ? ent_q.lvl + LVL_W'(1) : LEVEL_MAX;
            cur   <= next_q;
            state <= ST_W_RD;
          end
        end
        // spray: evict oldest when no entry is free
        ST_A0: begin
          if (free_cnt == CW'(0)) begin
            cur     <= head;
            evicted <= 1'b1;
            state   <= ST_R_RD;
          end else begin
            state <= ST_A1;
          end
        end
        ST_R_RD: state <= ST_R_UPD;
        ST_R_UPD: begin
          if (head == cur) head <= next_q;
          if (tail == cur) tail <= prev_q;
          free_cnt <= free_cnt + CW'(1);
          state    <= (mode == MODE_TICK) ? ST_T_NXT : ST_A1;
        end
        ST_A1: state <= ST_A2;
        ST_A2: begin
          cur      <= {{(LW-IW){1'b0}}, fs_q};
          free_cnt <= free_cnt - CW'(1);
          state    <= ST_A3;
        end
        ST_A3: begin
          tail <= cur;
          if (head == NIL) head <= cur;
          outw.kind  <= KIND_SPRAY;
          outw.idx   <= IDX_OUT_W'(cur_idx);
          outw.lvl   <= lvl;
          outw.ev    <= evicted;
          outw.red   <= in_red;
          outw.green <= in_green;
          outw.blue  <= in_blue;
          outw.alpha <= in_alpha;
          outw.last  <= 1'b1;
          out_v      <= 1'b1;
          state      <= ST_OUTW;
        end
        // tick: walk, free expired entries, fade those past hold time, pass the rest
        ST_T_RD: state <= (cur == NIL) ? ST_T_END : ST_T_AGE;
        ST_T_AGE: begin
          nx <= next_q;
          if (age >= fade_end) begin
            state <= ST_R_UPD;
          end else if (age < hold_time) begin
            chan[0] <= ent_q.red;
            chan[1] <= ent_q.green;
            chan[2] <= ent_q.blue;
            chan[3] <= ent_q.alpha;
            state   <= ST_T_PSH;
          end else begin
            num   <= fade_end - age;
            den   <= fade_end - hold_time;
            ch    <= 2'd0;
            state <= ST_T_MUL;
          end
        end
        ST_T_MUL: state <= ST_T_MW;
        ST_T_MW:  state <= ST_T_DIV;
        ST_T_DIV: begin
          if (!div_busy) begin
            chan[ch] <= div_q;
            ch       <= ch + 2'd1;
            state    <= (ch == 2'd3) ? ST_T_PSH : ST_T_MUL;
          end
        end
        // hold one visible word back so the final one can carry last
        ST_T_PSH: begin
          pend   <= fresh;
          pend_v <= 1'b1;
          if (pend_v) begin
            outw  <= pend;
            out_v <= 1'b1;
            state <= ST_OUTW;
          end else begin
            state <= ST_T_NXT;
          end
        end
        ST_T_NXT: begin
          cur   <= nx;
          state <= ST_T_RD;
        end
        ST_T_END: begin
          if (pend_v) begin
            outw <= out_word_t'({pend[$bits(out_word_t)-1:1], 1'b1});
          end else begin
            outw <= out_word_t'({KIND_EMPTY, {($bits(out_word_t)-3){1'b0}}, 1'b1});
          end
          pend_v <= 1'b0;
          out_v  <= 1'b1;
          state  <= ST_OUTW;
        end
        ST_OUTW: begin
          if (m_tready) begin
            out_v <= 1'b0;
            state <= outw.last ? ST_IDLE : ST_T_NXT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_v;
  assign m_tuser  = outw.kind;
  assign m_tlast  = outw.last;
  assign m_tdata  = {2'b00, outw.alpha, outw.blue, outw.green, outw.red,
                     outw.ev, outw.lvl, outw.idx};

  // checks
  `DPF_ASSERT_NOW(a_idle_no_out, s_tready, !m_tvalid)
  `DPF_ASSERT_NOW(a_cnt_bound, 1'b1, free_cnt <= CW'(POOL_ENTRIES))
  `DPF_ASSERT_NOW(a_list_ends, 1'b1, (head == NIL) == (tail == NIL))
  `DPF_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

endmodule
